// ----- design/tdfc_pkg.sv -----
package tdfc_pkg;

    // Frame geometry
    localparam int FRAME_LEN = 20;
    localparam int SUM_LEN   = 16;

    // Trailer and header bytes
    localparam logic [7:0] TRAILER_A = 8'h44;
    localparam logic [7:0] TRAILER_B = 8'h55;
    localparam logic [7:0] HEADER_A  = 8'h22;
    localparam logic [7:0] HEADER_B  = 8'h33;

    typedef logic [7:0] t_byte;

    // Receive window, entry FRAME_LEN-1 newest
    typedef logic [FRAME_LEN-1:0][7:0] t_win;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_HEADER     = 2'd1,
        ST_CHECKSUM   = 2'd2,
        ST_INCOMPLETE = 2'd3
    } t_status;

    // Pending frame check handed from the window to the checker
    typedef struct packed {
        logic vld;
        logic incomplete;
    } t_chk_req;

endpackage

// ----- design/tdfc_window.sv -----
module tdfc_window import tdfc_pkg::*; #(
    parameter int MAX_COUNT = 255
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_byte    i_rx_byte,
    input  logic     i_chk_ready,
    output t_chk_req o_req,
    output t_win     o_win
);

    localparam logic [7:0] LIMIT = MAX_COUNT[7:0];

    t_win     r_win;
    t_win     n_win;
    logic [7:0] r_cnt;
    logic [7:0] n_cnt;
    t_chk_req r_req;
    t_chk_req n_req;
    logic     accept;
    logic     consume;
    logic [7:0] cnt_inc;
    logic     trailer;

    // Hold the window while a detected frame waits for the checker
    assign o_stall = r_req.vld && !i_chk_ready;
    assign accept  = i_valid && !o_stall;
    assign consume = r_req.vld && i_chk_ready;

    assign cnt_inc = r_cnt + 8'd1;
    assign trailer = (cnt_inc >= 8'd2) && (r_win[FRAME_LEN-1] == TRAILER_A)
                     && (i_rx_byte == TRAILER_B);

    // Advance count, detect trailer, clear on check or at the limit
    always_comb begin
        n_cnt = r_cnt;
        n_req = r_req;
        if (consume) begin
            n_req.vld = 1'b0;
        end
        if (accept) begin
            if (trailer) begin
                n_cnt            = '0;
                n_req.vld        = 1'b1;
                n_req.incomplete = (cnt_inc < 8'(FRAME_LEN));
            end else if (cnt_inc >= LIMIT) begin
                n_cnt = '0;
            end else begin
                n_cnt = cnt_inc;
            end
        end
    end

    // Shift the new byte in at the newest end
    assign n_win = {i_rx_byte, r_win[FRAME_LEN-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_req <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_req <= n_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

    assign o_req = r_req;
    assign o_win = r_win;

`ifndef SYNTHESIS
    a_cnt_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < LIMIT)
        else $error("byte count reached limit");

    a_trailer_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && trailer |=> r_cnt == 8'd0 && r_req.vld)
        else $error("trailer did not clear count or raise check");

    a_pending_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req.vld && !i_chk_ready |=> r_req.vld && $stable(r_win))
        else $error("pending frame window changed");
`endif

endmodule

// ----- design/tdfc_check.sv -----
module tdfc_check import tdfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chk_req    i_req,
    input  t_win        i_win,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_command_code,
    output logic [31:0] o_index_word,
    output logic [31:0] o_payload_word
);

    logic        r_vld;
    t_status     r_status;
    logic [7:0]  r_cmd;
    logic [31:0] r_idx;
    logic [31:0] r_pay;
    t_status     n_status;
    logic [7:0]  n_cmd;
    logic [31:0] n_idx;
    logic [31:0] n_pay;
    logic [15:0] sum;
    logic [15:0] want;
    logic        hdr_ok;
    logic        load;

    // Result register takes a request when empty or being drained
    assign o_ready = !r_vld || !i_stall;
    assign load    = i_req.vld && o_ready;

    // Sum the first SUM_LEN frame bytes as a balanced tree
    always_comb begin
        logic [15:0] s8 [8];
        logic [15:0] s4 [4];
        logic [15:0] s2 [2];
        for (int k = 0; k < 8; k++) begin
            s8[k] = 16'(i_win[2*k]) + 16'(i_win[2*k+1]);
        end
        for (int k = 0; k < 4; k++) begin
            s4[k] = s8[2*k] + s8[2*k+1];
        end
        for (int k = 0; k < 2; k++) begin
            s2[k] = s4[2*k] + s4[2*k+1];
        end
        sum = s2[0] + s2[1];
    end

    assign want   = {i_win[SUM_LEN], i_win[SUM_LEN+1]};
    assign hdr_ok = (i_win[0] == HEADER_A) && (i_win[1] == HEADER_B);

    // Classify the frame; header failure wins over checksum failure
    always_comb begin
        n_cmd = '0;
        n_idx = '0;
        n_pay = '0;
        if (i_req.incomplete) begin
            n_status = ST_INCOMPLETE;
        end else if (!hdr_ok) begin
            n_status = ST_HEADER;
        end else if (sum != want) begin
            n_status = ST_CHECKSUM;
        end else begin
            n_status = ST_OK;
            n_cmd    = i_win[2];
            n_idx    = {i_win[3], i_win[4], i_win[5], i_win[6]};
            n_pay    = {i_win[7], i_win[8], i_win[9], i_win[10]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_req.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= n_status;
            r_cmd    <= n_cmd;
            r_idx    <= n_idx;
            r_pay    <= n_pay;
        end
    end

    assign o_valid        = r_vld;
    assign o_frame_status = r_status;
    assign o_command_code = r_cmd;
    assign o_index_word   = r_idx;
    assign o_payload_word = r_pay;

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_vld)
        else $error("loaded result not presented");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_status != ST_OK |-> r_cmd == 8'd0 && r_idx == 32'd0 && r_pay == 32'd0)
        else $error("failed frame carries nonzero fields");

    a_incomplete_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && i_req.incomplete |=> r_status == ST_INCOMPLETE)
        else $error("short frame not flagged incomplete");
`endif

endmodule

// ----- design/trailer_delimited_frame_checker_unit.sv -----
// Trailer-delimited frame checker.
// Input channel: one received byte per request on i_rx_byte, taken at a
// rising edge with i_valid high and o_stall low. Output channel: one frame
// report per request (status, command, index, payload), taken at a rising
// edge with o_valid high and i_stall low.
// A report is raised when the two newest bytes are 0x44 then 0x55. The
// status flags an incomplete, bad-header or bad-checksum frame; on those the
// other fields read zero.
// A report appears on o_valid after the byte that completes the trailer is
// taken: the window register takes the byte and raises the pending check,
// and the result register takes the report once it is empty or drained.
// Throughput: one byte per cycle while o_stall is low; the 16-byte checksum
// is a four-level adder tree from the window register to the result register.
// Reset clears the byte count, the pending check and the result valid; the
// window contents are left as they are and are never read unwritten.
// When the receiver stalls, the held report stays on the outputs; one more
// report may wait behind it, after which o_stall rises and bytes are held
// off until the receiver drains.
module trailer_delimited_frame_checker_unit import tdfc_pkg::*; #(
    parameter int MAX_COUNT = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_command_code,
    output logic [31:0] o_index_word,
    output logic [31:0] o_payload_word
);

    t_chk_req chk_req;
    t_win     win;
    logic     chk_ready;

    // Receive window, byte count and trailer detection
    tdfc_window #(
        .MAX_COUNT (MAX_COUNT)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .i_chk_ready (chk_ready),
        .o_req       (chk_req),
        .o_win       (win)
    );

    // Frame check and result register
    tdfc_check u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (chk_req),
        .i_win          (win),
        .o_ready        (chk_ready),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_status (o_frame_status),
        .o_command_code (o_command_code),
        .o_index_word   (o_index_word),
        .o_payload_word (o_payload_word)
    );

`ifndef SYNTHESIS
    a_stall_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> chk_req.vld && o_valid && i_stall)
        else $error("input stalled without a blocked report");

    a_pending_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chk_req.vld && !i_stall |=> o_valid)
        else $error("pending report not moved to output");

    a_no_report_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled report dropped");
`endif

endmodule
